// ===== src/crr_pkg.sv =====
// crr_pkg: opcodes, status codes, command kinds and the structs shared by
// the front end, the back end and the port checker of the result ring.
// No dependencies.
package crr_pkg;

  // field widths fixed by the stream format
  localparam int OP_W     = 3;
  localparam int STATUS_W = 3;
  localparam int DATA_W   = 32;
  localparam int CAP_W    = 7;
  localparam int CNT_W    = 32;

  // packed result word: value, pending, credits, reject total, padding
  localparam int OUT_BITS  = DATA_W + CAP_W + CAP_W + CNT_W;
  localparam int OUT_TDATA = ((OUT_BITS + 7) / 8) * 8;

  // command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  // input opcodes
  localparam logic [OP_W-1:0] OP_RESERVE = 3'd0;
  localparam logic [OP_W-1:0] OP_PUBLISH = 3'd1;
  localparam logic [OP_W-1:0] OP_CANCEL  = 3'd2;
  localparam logic [OP_W-1:0] OP_DRAIN   = 3'd3;
  localparam logic [OP_W-1:0] OP_STOP    = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_RES   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

  // decoded command kind
  typedef enum logic [2:0] {
    K_RESERVE,
    K_PUBLISH,
    K_CANCEL,
    K_DRAIN,
    K_STOP,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [DATA_W-1:0] payload;
  } cmd_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   value;
    logic                last;
    logic [CAP_W-1:0]    pending;
    logic [CAP_W-1:0]    credits;
    logic [CNT_W-1:0]    rejects;
  } result_t;

endpackage

// ===== src/credit_reserved_result_ring.sv =====
// credit_reserved_result_ring: top level; front end and command queue,
// back end bookkeeping, slot RAM. Uses crr_pkg, crr_front, crr_back, crr_ram.
// An input is held in the command queue, its result in the output register;
//   a drain reads its first slot ahead, then one value per free output cycle.
// Throughput: one item per cycle for reserve, publish, cancel and stop while
//   the output is free; a drain holds the back end until its last value.
// Reset: rst_n synchronous, clears control state; slot RAM is not cleared.
module credit_reserved_result_ring #(
  parameter int RING_DEPTH = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration: ring_capacity
  input  logic                           cfg_we,
  input  logic [crr_pkg::CAP_W-1:0]      cfg_wdata,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [crr_pkg::DATA_W-1:0]     in_tdata,  // [31:0] payload
  input  logic [crr_pkg::OP_W-1:0]       in_tuser,  // [2:0] opcode
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [31:0] drained_value, [38:32] pending_count, [45:39] credits_left,
  // [77:46] reject_total, [79:78] zero
  output logic [crr_pkg::OUT_TDATA-1:0]  out_tdata,
  output logic [crr_pkg::STATUS_W-1:0]   out_tuser, // [2:0] status
  output logic                           out_tlast  // last
);
  import crr_pkg::*;

  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int STORE_BITS = (VALUE_BITS < 32) ? VALUE_BITS : 32;

  q_t                    q;
  logic                  q_ready;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr, ram_raddr;
  logic [STORE_BITS-1:0] ram_wdata, ram_rdata;
  result_t               res;

  crr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q         (q),
    .q_ready   (q_ready)
  );

  crr_back #(
    .RING_DEPTH (RING_DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q         (q),
    .q_ready   (q_ready),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out       (res)
  );

  crr_ram #(
    .WIDTH (STORE_BITS),
    .DEPTH (RING_DEPTH)
  ) u_slots (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  // result packing
  assign out_tdata = OUT_TDATA'({res.rejects, res.credits, res.pending, res.value});
  assign out_tuser = res.status;
  assign out_tlast = res.last;

endmodule

// ===== src/crr_ram.sv =====
// crr_ram: generic single-write, single-read RAM with registered read data.
// Standalone, no package dependency.
module crr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// ===== src/crr_front.sv =====
// crr_front: accepts input transfers, decodes the opcode into a command kind
// and holds commands in a short queue for the back end. Uses crr_pkg.
module crr_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [crr_pkg::DATA_W-1:0] in_tdata,
  input  logic [crr_pkg::OP_W-1:0]   in_tuser,
  output crr_pkg::q_t               q,
  input  logic                      q_ready
);
  import crr_pkg::*;

  cmd_t               entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               push, pop;
  cmd_t               cmd_in;

  // opcode decode
  always_comb begin
    cmd_in.payload = in_tdata;
    unique case (in_tuser)
      OP_RESERVE: cmd_in.kind = K_RESERVE;
      OP_PUBLISH: cmd_in.kind = K_PUBLISH;
      OP_CANCEL:  cmd_in.kind = K_CANCEL;
      OP_DRAIN:   cmd_in.kind = K_DRAIN;
      OP_STOP:    cmd_in.kind = K_STOP;
      default:    cmd_in.kind = K_NOP;
    endcase
  end

  // queue control
  assign in_tready = (count_r != Q_CNT_W'(Q_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q.valid   = (count_r != '0);
  assign q.cmd     = entry_r[rd_ptr_r];
  assign pop       = q.valid && q_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

// ===== src/crr_back.sv =====
// crr_back: credit and ring bookkeeping, slot memory control, drain
// sequencing and the result output register. Uses crr_pkg; drives crr_ram.
module crr_back #(
  parameter int RING_DEPTH = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [crr_pkg::CAP_W-1:0]     cfg_wdata,
  input  crr_pkg::q_t                   q,
  output logic                          q_ready,
  output logic                          ram_we,
  output logic [$clog2(RING_DEPTH)-1:0] ram_waddr,
  output logic [((VALUE_BITS < 32) ? VALUE_BITS : 32)-1:0] ram_wdata,
  output logic [$clog2(RING_DEPTH)-1:0] ram_raddr,
  input  logic [((VALUE_BITS < 32) ? VALUE_BITS : 32)-1:0] ram_rdata,
  output logic                          out_valid,
  input  logic                          out_ready,
  output crr_pkg::result_t              out
);
  import crr_pkg::*;

  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int STORE_BITS = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'((RING_DEPTH < 64) ? RING_DEPTH : 64);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [IDX_W-1:0] head_inc, tail_inc;
  logic [CAP_W-1:0] pending_r, pending_nxt;
  logic [CAP_W-1:0] credit_r, credit_nxt;
  logic [CAP_W-1:0] open_r, open_nxt;
  logic             accepting_r, accepting_nxt;
  logic [CNT_W-1:0] reject_r, reject_nxt;
  logic             out_valid_r, out_valid_nxt;
  result_t          out_r, out_nxt;
  logic [CAP_W-1:0] cap_wr;
  logic             out_free, take, pop, emit, emit_last;
  logic [STATUS_W-1:0] emit_status;
  logic [DATA_W-1:0]   emit_value;

  // capacity clamp for a register write
  always_comb begin
    if (cfg_wdata == '0) begin
      cap_wr = CAP_W'(1);
    end else if (cfg_wdata > CAP_MAX) begin
      cap_wr = CAP_MAX;
    end else begin
      cap_wr = cfg_wdata;
    end
  end

  // index increments that wrap at the configured capacity
  assign head_inc = ((CAP_W'(head_r) + 1'b1) >= cap_r) ? '0 : head_r + 1'b1;
  assign tail_inc = ((CAP_W'(tail_r) + 1'b1) >= cap_r) ? '0 : tail_r + 1'b1;

  assign out_free = !out_valid_r || out_ready;
  assign q_ready  = (state_r == S_IDLE) && out_free;
  assign take     = q.valid && q_ready;
  assign pop      = (state_r == S_POP) && out_free;

  // slot memory ports
  assign ram_waddr = head_r;
  assign ram_wdata = STORE_BITS'(q.cmd.payload);
  assign ram_raddr = pop ? tail_inc : tail_r;

  // command execution
  always_comb begin
    state_nxt     = state_r;
    cap_nxt       = cap_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    pending_nxt   = pending_r;
    credit_nxt    = credit_r;
    open_nxt      = open_r;
    accepting_nxt = accepting_r;
    reject_nxt    = reject_r;
    ram_we        = 1'b0;
    emit          = 1'b0;
    emit_status   = ST_OK;
    emit_value    = '0;
    emit_last     = 1'b1;

    if (take) begin
      unique case (q.cmd.kind)
        K_RESERVE: begin
          emit = 1'b1;
          if (!accepting_r || credit_r == '0) begin
            emit_status = ST_REJECTED;
            if (reject_r != '1) begin
              reject_nxt = reject_r + 1'b1;
            end
          end else begin
            credit_nxt = credit_r - 1'b1;
            open_nxt   = open_r + 1'b1;
          end
        end
        K_PUBLISH: begin
          emit = 1'b1;
          if (open_r == '0) begin
            emit_status = ST_NO_RES;
          end else if (pending_r >= cap_r) begin
            emit_status = ST_OVERFLOW;
            open_nxt    = open_r - 1'b1;
            if (credit_r < cap_r) begin
              credit_nxt = credit_r + 1'b1;
            end
          end else begin
            open_nxt    = open_r - 1'b1;
            ram_we      = 1'b1;
            head_nxt    = head_inc;
            pending_nxt = pending_r + 1'b1;
          end
        end
        K_CANCEL: begin
          emit = 1'b1;
          if (open_r == '0) begin
            emit_status = ST_NO_RES;
          end else begin
            open_nxt = open_r - 1'b1;
            if (credit_r < cap_r) begin
              credit_nxt = credit_r + 1'b1;
            end
          end
        end
        K_DRAIN: begin
          if (pending_r == '0) begin
            emit        = 1'b1;
            emit_status = ST_EMPTY;
          end else begin
            state_nxt = S_RD;
          end
        end
        K_STOP: begin
          emit          = 1'b1;
          accepting_nxt = 1'b0;
        end
        default: begin
          emit = 1'b1;
        end
      endcase
    end

    // drain sequencer: one read ahead, then one pop per free output cycle
    unique case (state_r)
      S_RD: begin
        state_nxt = S_POP;
      end
      S_POP: begin
        if (pop) begin
          emit        = 1'b1;
          emit_value  = DATA_W'(ram_rdata);
          tail_nxt    = tail_inc;
          pending_nxt = pending_r - 1'b1;
          emit_last   = (pending_r == CAP_W'(1));
          if (credit_r < cap_r) begin
            credit_nxt = credit_r + 1'b1;
          end
          if (pending_r == CAP_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
      end
    endcase

    // cap write restarts ring; user must write only while idle, unchecked
    if (cfg_we) begin
      cap_nxt     = cap_wr;
      head_nxt    = '0;
      tail_nxt    = '0;
      pending_nxt = '0;
      open_nxt    = '0;
      credit_nxt  = cap_wr;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt   = 1'b1;
      out_nxt.status  = emit_status;
      out_nxt.value   = emit_value;
      out_nxt.last    = emit_last;
      out_nxt.pending = pending_nxt;
      out_nxt.credits = credit_nxt;
      out_nxt.rejects = reject_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CAP_MAX;
      head_r      <= '0;
      tail_r      <= '0;
      pending_r   <= '0;
      credit_r    <= CAP_MAX;
      open_r      <= '0;
      accepting_r <= 1'b1;
      reject_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      pending_r   <= pending_nxt;
      credit_r    <= credit_nxt;
      open_r      <= open_nxt;
      accepting_r <= accepting_nxt;
      reject_r    <= reject_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out       = out_r;

endmodule

// ===== src/crr_checker.sv =====
// crr_checker: port-level assertions for credit_reserved_result_ring and
// the bind that attaches them. Uses crr_pkg.
module crr_checker #(
  parameter int RING_DEPTH = 64
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [crr_pkg::OUT_TDATA-1:0] out_tdata,
  input logic [crr_pkg::STATUS_W-1:0]  out_tuser,
  input logic                          out_tlast
);
  import crr_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // every non-ok result is a single result
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tlast)
    else $error("non-ok result not marked last");

  // only ok results may carry a drained value
  a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata[DATA_W-1:0] == '0)
    else $error("non-ok result carries a value");

  // pending values plus free credits never exceed the built depth
  a_budget: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({1'b0, out_tdata[DATA_W +: CAP_W]}
      + {1'b0, out_tdata[DATA_W + CAP_W +: CAP_W]}) <= (CAP_W + 1)'(RING_DEPTH))
    else $error("pending plus credits beyond ring depth");

endmodule

bind credit_reserved_result_ring crr_checker #(
  .RING_DEPTH (RING_DEPTH)
) u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ===== bench/credit_reserved_result_ring_test.sv =====
// credit_reserved_result_ring_test: self-checking bench for the credit guarded result ring.
// Drives the item stream and the capacity register, predicts every result in order.
// Depends on crr_pkg and credit_reserved_result_ring.
module credit_reserved_result_ring_test;
  import crr_pkg::*;

  localparam int RING_DEPTH    = 64;
  localparam int VALUE_BITS    = 32;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 12;
  localparam int REPORT_MAX    = 10;
  localparam int OP_CODES      = 1 << OP_W;

  localparam logic [CAP_W-1:0] CAP_ZERO     = '0;
  localparam logic [CAP_W-1:0] CAP_ALL_ONES = '1;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [CAP_W-1:0]     cfg_wdata  = '0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [DATA_W-1:0]    in_tdata   = '0;  // [31:0] payload
  logic [OP_W-1:0]      in_tuser   = OP_RESERVE;  // [2:0] opcode
  logic                 out_tvalid;
  logic                 out_tready = 1'b1;
  // [31:0] drained_value, [38:32] pending_count, [45:39] credits_left,
  // [77:46] reject_total, [79:78] zero
  logic [OUT_TDATA-1:0] out_tdata;
  logic [STATUS_W-1:0]  out_tuser;  // [2:0] status
  logic                 out_tlast;

  // ring state as predicted
  logic [DATA_W-1:0] ring_slots [RING_DEPTH];
  int unsigned       ring_head;
  int unsigned       ring_tail;
  int unsigned       ring_pending;
  int unsigned       ring_credits;
  int unsigned       ring_open;
  int unsigned       ring_capacity;
  bit                ring_accepting;
  logic [CNT_W-1:0]  ring_rejects;
  result_t           awaited_results[$];

  // bookkeeping
  bit quiet_run    = 1'b0;
  int errors       = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int values_drained = 0;
  int cfg_writes   = 0;
  int idle_cycles  = 0;
  int ready_hold   = 0;

  credit_reserved_result_ring #(
    .RING_DEPTH(RING_DEPTH),
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- prediction

  function automatic int unsigned ring_advance(int unsigned idx);
    return (idx + 1 >= ring_capacity) ? 0 : idx + 1;
  endfunction

  function automatic void ring_set_capacity(logic [CAP_W-1:0] wdata);
    if (wdata == CAP_ZERO) begin
      ring_capacity = 1;
    end else if (wdata > RING_DEPTH) begin
      ring_capacity = RING_DEPTH;
    end else begin
      ring_capacity = 32'(wdata);
    end
    // the ring restarts empty, slots, stop and reject count are kept
    ring_head    = 0;
    ring_tail    = 0;
    ring_pending = 0;
    ring_open    = 0;
    ring_credits = ring_capacity;
  endfunction

  function automatic void expect_result(logic [STATUS_W-1:0] status,
                                        logic [DATA_W-1:0] value, logic last);
    result_t r;
    r.status  = status;
    r.value   = value;
    r.last    = last;
    r.pending = ring_pending[CAP_W-1:0];
    r.credits = ring_credits[CAP_W-1:0];
    r.rejects = ring_rejects;
    awaited_results.push_back(r);
  endfunction

  function automatic void predict_ring_results(logic [OP_W-1:0] op,
                                               logic [DATA_W-1:0] payload);
    logic [DATA_W-1:0] popped;
    case (op)
      OP_RESERVE: begin
        if (!ring_accepting || ring_credits == 0) begin
          if (ring_rejects != '1) ring_rejects++;
          expect_result(ST_REJECTED, '0, 1'b1);
        end else begin
          ring_credits--;
          ring_open++;
          expect_result(ST_OK, '0, 1'b1);
        end
      end
      OP_PUBLISH: begin
        if (ring_open == 0) begin
          expect_result(ST_NO_RES, '0, 1'b1);
        end else begin
          ring_open--;
          if (ring_pending >= ring_capacity) begin
            // full ring: reservation used up, credit handed back, nothing stored
            if (ring_credits < ring_capacity) ring_credits++;
            expect_result(ST_OVERFLOW, '0, 1'b1);
          end else begin
            ring_slots[ring_head] = payload;
            ring_head = ring_advance(ring_head);
            ring_pending++;
            expect_result(ST_OK, '0, 1'b1);
          end
        end
      end
      OP_CANCEL: begin
        if (ring_open == 0) begin
          expect_result(ST_NO_RES, '0, 1'b1);
        end else begin
          ring_open--;
          if (ring_credits < ring_capacity) ring_credits++;
          expect_result(ST_OK, '0, 1'b1);
        end
      end
      OP_DRAIN: begin
        if (ring_pending == 0) begin
          expect_result(ST_EMPTY, '0, 1'b1);
        end else begin
          while (ring_pending != 0) begin
            popped = ring_slots[ring_tail];
            ring_tail = ring_advance(ring_tail);
            ring_pending--;
            if (ring_credits < ring_capacity) ring_credits++;
            expect_result(ST_OK, popped, ring_pending == 0);
            values_drained++;
          end
        end
      end
      OP_STOP: begin
        ring_accepting = 1'b0;
        expect_result(ST_OK, '0, 1'b1);
      end
      default: begin
        // unused opcodes pass through with a plain ok
        expect_result(ST_OK, '0, 1'b1);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- drivers

  function automatic logic [DATA_W-1:0] random_payload();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
      default: return $urandom();
    endcase
  endfunction

  // one item on the input stream, predicted once its transfer is seen
  task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] payload);
    if (!quiet_run && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= payload;
    do @(posedge clk); while (!in_tready);
    predict_ring_results(op, payload);
    items_sent++;
  endtask

  // hold the input until every awaited result has come back
  task automatic wait_ring_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    wait_ring_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    ring_set_capacity(value);
    cfg_writes++;
  endtask

  // receiver stalls at random, in bursts of random length
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      if (ready_hold == 1) out_tready <= 1'b1;
    end else if (!quiet_run && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      ready_hold <= $urandom_range(1, 9);
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic report_field(input string field, input logic [CNT_W-1:0] want,
                              input logic [CNT_W-1:0] got);
    errors++;
    if (errors <= REPORT_MAX)
      $display("result %0d: %s expected %0h, got %0h", results_seen, field, want, got);
  endtask

  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen.status  = out_tuser;
      seen.value   = out_tdata[DATA_W-1:0];
      seen.last    = out_tlast;
      seen.pending = out_tdata[DATA_W +: CAP_W];
      seen.credits = out_tdata[DATA_W + CAP_W +: CAP_W];
      seen.rejects = out_tdata[DATA_W + 2 * CAP_W +: CNT_W];
      results_seen++;
      if (awaited_results.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("result %0d: none awaited, got status %0h value %0h",
                   results_seen, seen.status, seen.value);
      end else begin
        want = awaited_results.pop_front();
        if (seen.status !== want.status)
          report_field("status", CNT_W'(want.status), CNT_W'(seen.status));
        if (seen.value !== want.value) report_field("drained_value", want.value, seen.value);
        if (seen.last !== want.last)
          report_field("last", CNT_W'(want.last), CNT_W'(seen.last));
        if (seen.pending !== want.pending)
          report_field("pending_count", CNT_W'(want.pending), CNT_W'(seen.pending));
        if (seen.credits !== want.credits)
          report_field("credits_left", CNT_W'(want.credits), CNT_W'(seen.credits));
        if (seen.rejects !== want.rejects)
          report_field("reject_total", want.rejects, seen.rejects);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("stalled for %0d cycles with %0d results awaited",
             idle_cycles, awaited_results.size());
    $display("credit_reserved_result_ring_test: errors");
    $finish;
  end

  // ---------------------------------------------------------------- tests

  // every opcode but stop, empty drain, publish and cancel without reservation
  task automatic test_basic_ops();
    send_item(OP_DRAIN, random_payload());
    send_item(OP_PUBLISH, '1);
    send_item(OP_CANCEL, '0);
    send_item(OP_RESERVE, '1);
    send_item(OP_PUBLISH, '0);
    send_item(OP_RESERVE, '0);
    send_item(OP_PUBLISH, '1);
    send_item(OP_RESERVE, random_payload());
    send_item(OP_CANCEL, '1);
    send_item(OP_DRAIN, '0);
    for (int k = OP_STOP + 1; k < OP_CODES; k++) send_item(k[OP_W-1:0], random_payload());
  endtask

  // zero acts as one slot, all ones acts as full depth
  task automatic test_capacity_extremes();
    write_capacity(CAP_ZERO);
    send_item(OP_RESERVE, '0);
    send_item(OP_RESERVE, '0);
    send_item(OP_PUBLISH, 32'hA5A5_5A5A);
    send_item(OP_RESERVE, '0);
    send_item(OP_DRAIN, '0);
    send_item(OP_RESERVE, '0);
    send_item(OP_CANCEL, '0);
    write_capacity(CAP_ALL_ONES);
    send_item(OP_RESERVE, '0);
    send_item(OP_PUBLISH, 32'h5A5A_A5A5);
    send_item(OP_DRAIN, '0);
  endtask

  // reserve a batch, publish or cancel it with some noise, usually drain
  task automatic run_batch(input int unsigned count);
    logic [OP_W-1:0] noise_op;
    bit interleave;
    interleave = 1'($urandom_range(0, 1));
    if (!interleave) for (int i = 0; i < count; i++) send_item(OP_RESERVE, random_payload());
    for (int i = 0; i < count; i++) begin
      if (interleave) send_item(OP_RESERVE, random_payload());
      if ($urandom_range(0, 4) == 0) begin
        send_item(OP_CANCEL, random_payload());
      end else begin
        send_item(OP_PUBLISH, random_payload());
      end
      if ($urandom_range(0, 9) == 0) begin
        noise_op = OP_W'($urandom_range(0, OP_CODES - 1));
        if (noise_op == OP_STOP) noise_op = OP_DRAIN;
        send_item(noise_op, random_payload());
      end
    end
    if ($urandom_range(0, 3) != 0) begin
      // sometimes let the ring settle completely before the drain
      if ($urandom_range(0, 3) == 0) wait_ring_idle();
      send_item(OP_DRAIN, random_payload());
    end
  endtask

  task automatic test_random_batches();
    logic [CAP_W-1:0] caps [6];
    int phase_start;
    int limit;
    bit full_done;
    caps = '{7'd1, 7'd3, 7'd64, 7'd37, 7'd2, 7'd64};
    full_done = 1'b0;
    foreach (caps[p]) begin
      write_capacity(caps[p]);
      phase_start = items_sent;
      // one batch fills the whole ring to its full depth
      if (ring_capacity == RING_DEPTH && !full_done) begin
        full_done = 1'b1;
        for (int i = 0; i < RING_DEPTH; i++) send_item(OP_RESERVE, random_payload());
        for (int i = 0; i < RING_DEPTH; i++) send_item(OP_PUBLISH, random_payload());
        send_item(OP_DRAIN, random_payload());
      end
      while (items_sent - phase_start < RANDOM_ITEMS / 6) begin
        limit = (ring_capacity < 6) ? ring_capacity : 6;
        run_batch($urandom_range(1, limit));
      end
    end
    // the sender holds off until nothing is outstanding
    wait_ring_idle();
  endtask

  // stop ends reservations for good, other operations go on
  task automatic test_stop_accepting();
    logic [OP_W-1:0] op;
    write_capacity(7'd5);
    send_item(OP_RESERVE, '0);
    send_item(OP_RESERVE, '0);
    send_item(OP_STOP, random_payload());
    send_item(OP_RESERVE, '0);
    send_item(OP_PUBLISH, random_payload());
    send_item(OP_CANCEL, '0);
    send_item(OP_DRAIN, '0);
    send_item(OP_CANCEL, '0);
    write_capacity(CAP_ALL_ONES);
    for (int i = 0; i < 20; i++) begin
      op = OP_W'($urandom_range(0, OP_CODES - 1));
      send_item(op, random_payload());
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    ring_set_capacity(CAP_ALL_ONES);
    ring_accepting = 1'b1;
    ring_rejects   = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_ops();
    test_capacity_extremes();
    test_random_batches();
    // last part of the run without idling on either side
    quiet_run = 1'b1;
    test_stop_accepting();
    wait_ring_idle();

    $display("covered %0d items, %0d results, %0d drained values, %0d capacity writes",
             items_sent, results_seen, values_drained, cfg_writes);
    $display("refused reservations %0d, mismatches %0d", ring_rejects, errors);
    if (errors == 0) begin
      $display("credit_reserved_result_ring_test: clean");
    end else begin
      $display("credit_reserved_result_ring_test: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/crr_pkg.sv
src/crr_ram.sv
src/crr_front.sv
src/crr_back.sv
src/credit_reserved_result_ring.sv
src/crr_checker.sv
bench/credit_reserved_result_ring_test.sv
